[design/fskm_pkg.sv]
// fskm_pkg: shared types, constants and the sine table for the FSK modulator.
// No dependencies; fskm_front, fskm_back and the top level refer to it by scoped names.
`default_nettype none

package fskm_pkg;

  // Fixed sizes
  localparam int unsigned FifoDepth    = 16;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);
  localparam int unsigned SineDepth    = 256;
  localparam int unsigned SineIdxW     = $clog2(SineDepth);
  localparam int unsigned SampleW      = 16;
  localparam int unsigned OutShift     = 31 - SampleW;
  localparam int unsigned ShapeW       = 17;   // [-32768, 32768]
  localparam int unsigned GainW        = 15;
  localparam int unsigned ProdW        = ShapeW + GainW + 1;
  localparam int unsigned PhaseW       = 32;
  localparam int unsigned SpbW         = 16;
  localparam int unsigned CarrierW     = 8;
  localparam int unsigned SlotW        = 4;
  localparam int unsigned BitsPerFrame = 1 + 8 + 1;
  localparam int unsigned SeqSteps     = 6;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned JobQDepth    = 4;
  localparam int unsigned OutQDepth    = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MARK_STEP  = 3'd0,
    CFG_SPACE_STEP = 3'd1,
    CFG_SPB        = 3'd2,
    CFG_WAVE       = 3'd3,
    CFG_GAIN       = 3'd4,
    CFG_LEAD_BITS  = 3'd5,
    CFG_TAIL_BITS  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SQUARE = 2'd3
  } wave_e;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_LEAD = 4'b0010,
    MODE_DATA = 4'b0100,
    MODE_TAIL = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [PhaseW-1:0]   mark_step;
    logic [PhaseW-1:0]   space_step;
    logic [SpbW-1:0]     samples_per_bit;
    logic [1:0]          wave_select;
    logic [GainW-1:0]    gain;
    logic [CarrierW-1:0] lead_bits;
    logic [CarrierW-1:0] tail_bits;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    mark_step:       32'd0,
    space_step:      32'd0,
    samples_per_bit: 16'd40,
    wave_select:     2'd0,
    gain:            15'd16384,
    lead_bits:       8'd10,
    tail_bits:       8'd10
  };

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      sample_valid;
    logic                      byte_accepted;
    logic                      burst_active;
    logic [FifoCntW-1:0]       queue_level;
  } out_t;

  // Per-transaction status that rides along with the sample work
  typedef struct packed {
    logic                tick;
    logic                accepted;
    logic                active;
    logic [FifoCntW-1:0] level;
  } flags_t;

  typedef struct packed {
    flags_t            flags;
    logic              gen;     // produce a tone sample from phase
    logic [PhaseW-1:0] phase;
  } job_t;

  typedef logic signed [ShapeW-1:0] shape_t;
  typedef shape_t [SineDepth-1:0] sine_tab_t;

  // Quarter-wave polynomial coefficients, Q30
  localparam longint unsigned Q30One = 64'd1073741824;
  localparam longint unsigned SinC1  = 64'd1686629713;
  localparam longint unsigned SinC3  = 64'd693598669;
  localparam longint unsigned SinC5  = 64'd85569305;
  localparam longint unsigned SinC7  = 64'd5026995;
  localparam longint unsigned SinC9  = 64'd172272;

  // Evaluated at elaboration only
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned u;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned acc;
    longint unsigned m;
    logic [1:0]      quad;
    logic [ShapeW-1:0] mag;
    for (int i = 0; i < SineDepth; i++) begin
      u    = (64'(unsigned'(i)) << 32) / SineDepth;
      quad = u[31:30];
      r    = u & (Q30One - 64'd1);
      x    = quad[0] ? (Q30One - r) : r;
      x2   = (x * x) >> 30;
      acc  = SinC7 - ((x2 * SinC9) >> 30);
      acc  = SinC5 - ((x2 * acc) >> 30);
      acc  = SinC3 - ((x2 * acc) >> 30);
      acc  = SinC1 - ((x2 * acc) >> 30);
      m    = (((x * acc) >> 30) + 64'd16384) >> 15;
      if (m > 64'd32768) begin
        m = 64'd32768;
      end
      mag    = ShapeW'(m);
      tab[i] = quad[1] ? shape_t'(17'd0 - mag) : shape_t'(mag);
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

endpackage

`default_nettype wire

[design/fskm_ram.sv]
// fskm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fskm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/fskm_queue.sv]
// fskm_queue: small flip-flop FIFO for transaction records.
// No dependencies.
`default_nettype none

module fskm_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               wdata_i,
  input  logic                           pop_i,
  output logic [Width-1:0]               rdata_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [$clog2(Depth + 1)-1:0]   count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[design/fskm_front.sv]
// fskm_front: accepts transactions, keeps the byte FIFO, the 8N1 bit sequencer
// and the phase accumulator. Depends on fskm_pkg and fskm_ram.
`default_nettype none

module fskm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fskm_pkg::cfg_t  cfg_i,
  input  fskm_pkg::in_t   item_i,
  input  logic            item_valid_i,
  input  logic            job_ready_i,
  output fskm_pkg::job_t  job_o,
  output logic            job_valid_o
);

  fskm_pkg::mode_e                      mode_q, mode_d;
  logic [fskm_pkg::FifoPtrW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [fskm_pkg::FifoCntW-1:0]        count_q, count_d;
  logic [fskm_pkg::PhaseW-1:0]          phase_q, phase_d;
  logic [fskm_pkg::SlotW-1:0]           slot_q, slot_d;
  logic [fskm_pkg::SpbW-1:0]            scnt_q, scnt_d;
  logic [fskm_pkg::CarrierW-1:0]        carrier_q, carrier_d;
  logic                                 tone_q, tone_d;

  logic                                 accept, is_tick;
  logic                                 ram_we, ram_re, seq_done, gen;
  logic [7:0]                           shift_byte;
  logic [fskm_pkg::PhaseW-1:0]          step;
  logic [fskm_pkg::SpbW-1:0]            spb;
  logic [fskm_pkg::SpbW:0]              scnt_next;

  assign accept  = item_valid_i && job_ready_i;
  assign is_tick = (item_i.req_type == fskm_pkg::REQ_TICK);
  assign spb     = (cfg_i.samples_per_bit == '0) ? fskm_pkg::SpbW'(1) : cfg_i.samples_per_bit;
  assign scnt_next = {1'b0, scnt_q} + 1'b1;

  // Byte storage; the read register doubles as the frame shift byte
  fskm_ram #(
    .Width (8),
    .Depth (fskm_pkg::FifoDepth)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (item_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (shift_byte)
  );

  always_comb begin
    mode_d    = mode_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    phase_d   = phase_q;
    slot_d    = slot_q;
    scnt_d    = scnt_q;
    carrier_d = carrier_q;
    tone_d    = tone_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    seq_done  = 1'b0;
    gen       = 1'b0;
    step      = '0;

    if (accept && !is_tick) begin
      if (count_q != fskm_pkg::FifoCntW'(fskm_pkg::FifoDepth)) begin
        ram_we  = 1'b1;
        tail_d  = (tail_q == fskm_pkg::FifoPtrW'(fskm_pkg::FifoDepth - 1)) ? '0
                                                                           : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end
    end else if (accept) begin
      // Bit boundary: walk the burst sequencer until a bit is chosen
      if (scnt_q == '0) begin
        for (int k = 0; k < fskm_pkg::SeqSteps; k++) begin
          if (!seq_done) begin
            case (mode_d)
              fskm_pkg::MODE_IDLE: begin
                if (count_d == '0) begin
                  seq_done = 1'b1;
                end else begin
                  mode_d    = fskm_pkg::MODE_LEAD;
                  carrier_d = cfg_i.lead_bits;
                end
              end
              fskm_pkg::MODE_LEAD: begin
                if (carrier_d == '0) begin
                  mode_d = fskm_pkg::MODE_DATA;
                  slot_d = fskm_pkg::SlotW'(fskm_pkg::BitsPerFrame);
                end else begin
                  carrier_d = carrier_d - 1'b1;
                  tone_d    = 1'b1;
                  seq_done  = 1'b1;
                end
              end
              fskm_pkg::MODE_DATA: begin
                if (slot_d >= fskm_pkg::SlotW'(fskm_pkg::BitsPerFrame) && count_d == '0) begin
                  mode_d    = fskm_pkg::MODE_TAIL;
                  carrier_d = cfg_i.tail_bits;
                end else begin
                  if (slot_d >= fskm_pkg::SlotW'(fskm_pkg::BitsPerFrame)) begin
                    ram_re  = 1'b1;
                    head_d  = (head_q == fskm_pkg::FifoPtrW'(fskm_pkg::FifoDepth - 1)) ? '0
                                                                   : head_q + 1'b1;
                    count_d = count_d - 1'b1;
                    slot_d  = '0;
                  end
                  if (slot_d == '0) begin
                    tone_d = 1'b0;                      // start bit
                  end else if (slot_d >= fskm_pkg::SlotW'(fskm_pkg::BitsPerFrame - 1)) begin
                    tone_d = 1'b1;                      // stop bit
                  end else begin
                    tone_d = shift_byte[3'(slot_d - 1'b1)];
                  end
                  slot_d   = slot_d + 1'b1;
                  seq_done = 1'b1;
                end
              end
              fskm_pkg::MODE_TAIL: begin
                if (carrier_d == '0) begin
                  mode_d = fskm_pkg::MODE_IDLE;
                  tone_d = 1'b1;
                end else begin
                  carrier_d = carrier_d - 1'b1;
                  tone_d    = 1'b1;
                  seq_done  = 1'b1;
                end
              end
              default: begin
                seq_done = 1'b1;
              end
            endcase
          end
        end
      end

      if (mode_d != fskm_pkg::MODE_IDLE) begin
        step = tone_d ? cfg_i.mark_step : cfg_i.space_step;
        if (step != '0) begin
          gen     = 1'b1;
          phase_d = phase_q + step;
        end
        scnt_d = (scnt_next >= {1'b0, spb}) ? '0 : scnt_next[fskm_pkg::SpbW-1:0];
      end
    end
  end

  always_comb begin
    job_o.flags.tick     = is_tick;
    job_o.flags.accepted = ram_we;
    job_o.flags.active   = (mode_d != fskm_pkg::MODE_IDLE);
    job_o.flags.level    = count_d;
    job_o.gen            = gen;
    job_o.phase          = phase_q;
  end
  assign job_valid_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= fskm_pkg::MODE_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      phase_q   <= '0;
      slot_q    <= '0;
      scnt_q    <= '0;
      carrier_q <= '0;
      tone_q    <= 1'b1;
    end else begin
      mode_q    <= mode_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      phase_q   <= phase_d;
      slot_q    <= slot_d;
      scnt_q    <= scnt_d;
      carrier_q <= carrier_d;
      tone_q    <= tone_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (count_q != '0))
    else $error("byte FIFO read while empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fskm_pkg::FifoCntW'(fskm_pkg::FifoDepth))
    else $error("byte FIFO level beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && job_o.gen) |-> (job_o.flags.active && job_o.flags.tick))
    else $error("tone sample requested outside a burst tick");

endmodule

`default_nettype wire

[design/fskm_back.sv]
// fskm_back: waveform shaping, gain multiply and rounding, then the result queue.
// Depends on fskm_pkg and fskm_queue.
`default_nettype none

module fskm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fskm_pkg::cfg_t  cfg_i,
  input  fskm_pkg::job_t  job_i,
  input  logic            job_valid_i,
  output logic            job_pop_o,
  output fskm_pkg::out_t  result_o,
  output logic            empty_o,
  input  logic            pop_i
);

  localparam int unsigned OutCntW = $clog2(fskm_pkg::OutQDepth + 1);

  logic                               issue, credit_ok;
  logic [OutCntW-1:0]                 out_count;
  logic [OutCntW:0]                   in_flight;
  fskm_pkg::shape_t                   shape, saw, tri_w, sq_w;
  logic [fskm_pkg::ShapeW-1:0]        saw_abs;
  logic signed [fskm_pkg::ShapeW:0]   tri_wide;

  logic                               s1_valid_q, s2_valid_q;
  fskm_pkg::flags_t                   s1_flags_q, s2_flags_q;
  fskm_pkg::shape_t                   s1_shape_q;
  logic signed [fskm_pkg::ProdW-1:0]  s2_prod_q, s2_prod_d, rnd;
  fskm_pkg::out_t                     res;
  logic [$bits(fskm_pkg::out_t)-1:0]  q_rdata;

  // Issue only with room reserved for everything already in the pipe
  assign in_flight = {1'b0, out_count} + (OutCntW + 1)'(s1_valid_q) + (OutCntW + 1)'(s2_valid_q);
  assign credit_ok = (in_flight < (OutCntW + 1)'(fskm_pkg::OutQDepth));
  assign issue     = job_valid_i && credit_ok;
  assign job_pop_o = issue;

  // Shapes
  assign saw      = fskm_pkg::ShapeW'($signed({~job_i.phase[31], job_i.phase[30:16]}));
  assign saw_abs  = saw[fskm_pkg::ShapeW-1] ? fskm_pkg::ShapeW'(-saw) : fskm_pkg::ShapeW'(saw);
  assign tri_wide = $signed({saw_abs, 1'b0}) - $signed((fskm_pkg::ShapeW + 1)'(32768));
  assign tri_w    = tri_wide[fskm_pkg::ShapeW-1:0];
  assign sq_w     = job_i.phase[31] ? fskm_pkg::shape_t'(-32768) : fskm_pkg::shape_t'(32768);

  always_comb begin
    shape = '0;
    if (job_i.gen) begin
      case (cfg_i.wave_select)
        fskm_pkg::WAVE_SINE:
          shape = fskm_pkg::SineTab[job_i.phase[fskm_pkg::PhaseW-1 -: fskm_pkg::SineIdxW]];
        fskm_pkg::WAVE_SAW:    shape = saw;
        fskm_pkg::WAVE_TRI:    shape = tri_w;
        fskm_pkg::WAVE_SQUARE: shape = sq_w;
        default:               shape = '0;
      endcase
    end
  end

  assign s2_prod_d = fskm_pkg::ProdW'(s1_shape_q)
                   * fskm_pkg::ProdW'($signed({1'b0, cfg_i.gain}));

  // Round half up, floor shift
  assign rnd = s2_prod_q + fskm_pkg::ProdW'(1 << (fskm_pkg::OutShift - 1));

  always_comb begin
    res.sample        = rnd[fskm_pkg::OutShift +: fskm_pkg::SampleW];
    res.sample_valid  = s2_flags_q.tick;
    res.byte_accepted = s2_flags_q.accepted;
    res.burst_active  = s2_flags_q.active;
    res.queue_level   = s2_flags_q.level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_flags_q <= job_i.flags;
    s1_shape_q <= shape;
    s2_flags_q <= s1_flags_q;
    s2_prod_q  <= s2_prod_d;
  end

  fskm_queue #(
    .Width ($bits(fskm_pkg::out_t)),
    .Depth (fskm_pkg::OutQDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .wdata_i (res),
    .pop_i   (pop_i),
    .rdata_o (q_rdata),
    .full_o  (),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  assign result_o = fskm_pkg::out_t'(q_rdata);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (out_count < OutCntW'(fskm_pkg::OutQDepth)))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_flags_q.tick) |-> (s2_prod_q == '0))
    else $error("push transaction carries a nonzero sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> !empty_o)
    else $error("finished result missing from result queue");

endmodule

`default_nettype wire

[design/fsk_modulator_8n1.sv]
// fsk_modulator_8n1: top level of the continuous-phase FSK modulator, 8N1 framing.
// Depends on fskm_pkg, fskm_front, fskm_queue and fskm_back.
//
// Usage:
//  - Input channel (push/full): item_i.req_type selects a byte push (data_byte
//    goes into a 16-deep byte FIFO) or a sample tick. A transaction completes
//    at a rising edge with push high and full low.
//  - Result channel (empty/pop): every input transaction yields exactly one
//    result, in order. The oldest result sits on result_o while empty is low
//    and is taken at an edge with pop high.
//  - Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0 mark_step .. 6 tail_bits) at once; unknown indexes are ignored.
//    Write only while no transaction is in flight.
//  - Path: job queue, shape stage, multiply stage, then result queue.
//  - Throughput: one transaction per cycle, sustained while full stays low. The front
//    sequencer updates FIFO, bit timing and phase for one transaction each cycle; the
//    back runs a 2-stage shape/multiply pipeline.
//  - Reset: registers return to defaults (40 samples/bit, gain 0.5, 10 lead
//    and 10 tail bits), queues empty, burst idle, phase zero. No clearing
//    pass is needed, so push is taken from the first cycle after reset.
//  - Receiver stall: results collect in a 4-entry result queue, the back
//    stops taking jobs, the 4-entry job queue fills and full rises.
`default_nettype none

module fsk_modulator_8n1 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input transactions
  input  logic                              push,
  output logic                              full,
  input  fskm_pkg::in_t                     item_i,
  // result transactions
  output logic                              empty,
  input  logic                              pop,
  output fskm_pkg::out_t                    result_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [fskm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fskm_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  fskm_pkg::cfg_t cfg_q, cfg_d;

  fskm_pkg::job_t                 fe_job, be_job;
  logic                           fe_job_valid, be_job_pop;
  logic                           jq_full, jq_empty;
  logic [$bits(fskm_pkg::job_t)-1:0] jq_rdata;

  // Configuration registers; upper data bits beyond a register are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fskm_pkg::CFG_MARK_STEP:  cfg_d.mark_step       = cfg_wdata_i[fskm_pkg::PhaseW-1:0];
        fskm_pkg::CFG_SPACE_STEP: cfg_d.space_step      = cfg_wdata_i[fskm_pkg::PhaseW-1:0];
        fskm_pkg::CFG_SPB:        cfg_d.samples_per_bit = cfg_wdata_i[fskm_pkg::SpbW-1:0];
        fskm_pkg::CFG_WAVE:       cfg_d.wave_select     = cfg_wdata_i[1:0];
        fskm_pkg::CFG_GAIN:       cfg_d.gain            = cfg_wdata_i[fskm_pkg::GainW-1:0];
        fskm_pkg::CFG_LEAD_BITS:  cfg_d.lead_bits       = cfg_wdata_i[fskm_pkg::CarrierW-1:0];
        fskm_pkg::CFG_TAIL_BITS:  cfg_d.tail_bits       = cfg_wdata_i[fskm_pkg::CarrierW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fskm_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: FIFO, bit sequencer, phase accumulator
  fskm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item_i),
    .item_valid_i (push),
    .job_ready_i  (!jq_full),
    .job_o        (fe_job),
    .job_valid_o  (fe_job_valid)
  );

  assign full = jq_full;

  // Job queue decouples sequencing from sample synthesis
  fskm_queue #(
    .Width ($bits(fskm_pkg::job_t)),
    .Depth (fskm_pkg::JobQDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_job_valid),
    .wdata_i (fe_job),
    .pop_i   (be_job_pop),
    .rdata_o (jq_rdata),
    .full_o  (jq_full),
    .empty_o (jq_empty),
    .count_o ()
  );

  assign be_job = fskm_pkg::job_t'(jq_rdata);

  // Back: shape, gain, rounding, result queue
  fskm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (be_job),
    .job_valid_i (!jq_empty),
    .job_pop_o   (be_job_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire
